// File: rtl/biq_pkg.sv
// Shared constants, register indexes and types for the stereo biquad filter.
// No dependencies; the rtl files refer to this package by scoped names, the sim files import it.
`default_nettype none

package biq_pkg;

	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 32;
	localparam int HIST_BITS   = 32;
	localparam int COEF_FRAC   = COEF_BITS - 4;
	localparam int PRE_SHIFT   = 4;
	localparam int POST_SHIFT  = COEF_FRAC - PRE_SHIFT;
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MODE_W      = 2;
	localparam int IDX_W       = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_FF_COEF_0   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FF_COEF_1   = 3'd1;
	localparam logic [IDX_W-1:0] REG_FF_COEF_2   = 3'd2;
	localparam logic [IDX_W-1:0] REG_FB_COEF_1   = 3'd3;
	localparam logic [IDX_W-1:0] REG_FB_COEF_2   = 3'd4;
	localparam logic [IDX_W-1:0] REG_CHANNEL_MODE = 3'd5;

	// channel mode codes; the other two codes bypass the filter
	localparam logic [MODE_W-1:0] MODE_MONO   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STEREO = 2'd2;

	// unity gain on the current input
	localparam logic [COEF_BITS-1:0] FF0_RESET = COEF_BITS'(1) << COEF_FRAC;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] ff0;
		logic signed [COEF_BITS-1:0] ff1;
		logic signed [COEF_BITS-1:0] ff2;
		logic signed [COEF_BITS-1:0] fb1;
		logic signed [COEF_BITS-1:0] fb2;
		logic [MODE_W-1:0]           mode;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [HIST_BITS-1:0]   y1;
		logic signed [HIST_BITS-1:0]   y2;
	} hist_t;

endpackage

`default_nettype wire

// File: rtl/biq_in_if.sv
// Valid/ready channel carrying one input sample and its end-of-buffer mark.
// Depends on biq_pkg for the sample width.
`default_nettype none

interface biq_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_in;
	logic                                   block_end_in;

	modport source(output valid, sample_in, block_end_in, input ready);
	modport sink(input valid, sample_in, block_end_in, output ready);
endinterface

`default_nettype wire

// File: rtl/biq_out_if.sv
// Valid/ready channel carrying one filtered sample with channel and flags.
// Depends on biq_pkg for the sample width.
`default_nettype none

interface biq_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_out;
	logic                                   channel_out;
	logic                                   clipped;
	logic                                   block_end_out;

	modport source(output valid, sample_out, channel_out, clipped, block_end_out,
		input ready);
	modport sink(input valid, sample_out, channel_out, clipped, block_end_out,
		output ready);
endinterface

`default_nettype wire

// File: rtl/biq_cfg_regs.sv
// Coefficient and channel-mode registers behind the plain write port.
// Depends on biq_pkg.
`default_nettype none

module biq_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [biq_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [biq_pkg::COEF_BITS-1:0] cfg_wdata,
	output biq_pkg::cfg_t                      cfg
);

	biq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ff0  <= biq_pkg::FF0_RESET;
			cfg_q.ff1  <= '0;
			cfg_q.ff2  <= '0;
			cfg_q.fb1  <= '0;
			cfg_q.fb2  <= '0;
			cfg_q.mode <= biq_pkg::MODE_STEREO;
		end else if (cfg_we) begin
			case (cfg_index)
				biq_pkg::REG_FF_COEF_0:    cfg_q.ff0  <= cfg_wdata;
				biq_pkg::REG_FF_COEF_1:    cfg_q.ff1  <= cfg_wdata;
				biq_pkg::REG_FF_COEF_2:    cfg_q.ff2  <= cfg_wdata;
				biq_pkg::REG_FB_COEF_1:    cfg_q.fb1  <= cfg_wdata;
				biq_pkg::REG_FB_COEF_2:    cfg_q.fb2  <= cfg_wdata;
				biq_pkg::REG_CHANNEL_MODE: cfg_q.mode <= cfg_wdata[biq_pkg::MODE_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/biq_hist.sv
// Per-channel filter history (two inputs, two wide outputs) and the
// stereo channel toggle. Depends on biq_pkg.
`default_nettype none

module biq_hist (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            upd,
	input  wire logic                            toggle,
	input  wire logic                            last,
	input  wire logic [biq_pkg::CH_W-1:0]        ch,
	input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] x,
	input  wire logic signed [biq_pkg::HIST_BITS-1:0]   y,
	output biq_pkg::hist_t                       hist,
	output logic                                 next_ch
);

	biq_pkg::hist_t hist_q [biq_pkg::CHANNELS];
	logic           next_ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < biq_pkg::CHANNELS; i++) begin
				hist_q[i] <= '0;
			end
			next_ch_q <= 1'b0;
		end else begin
			if (upd) begin
				hist_q[ch].x2 <= hist_q[ch].x1;
				hist_q[ch].x1 <= x;
				hist_q[ch].y2 <= hist_q[ch].y1;
				hist_q[ch].y1 <= y;
			end
			// every buffer opens on the left channel
			if (toggle) begin
				next_ch_q <= last ? 1'b0 : ~next_ch_q;
			end
		end
	end

	assign hist    = hist_q[ch];
	assign next_ch = next_ch_q;

endmodule

`default_nettype wire

// File: rtl/biq_mac.sv
// Combinational biquad arithmetic: five products, floor, sum, round,
// saturation to history and sample ranges. Depends on biq_pkg.
`default_nettype none

module biq_mac (
	input  wire biq_pkg::cfg_t                          cfg,
	input  wire biq_pkg::hist_t                         hist,
	input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] x,
	output logic signed [biq_pkg::HIST_BITS-1:0]        y,
	output logic signed [biq_pkg::SAMPLE_BITS-1:0]      sample,
	output logic                                        clipped
);

	localparam int XP_W  = biq_pkg::COEF_BITS + biq_pkg::SAMPLE_BITS;
	localparam int YP_W  = biq_pkg::COEF_BITS + biq_pkg::HIST_BITS;
	localparam int ACC_W = YP_W + 3;
	localparam int HB    = biq_pkg::HIST_BITS;
	localparam int SB    = biq_pkg::SAMPLE_BITS;

	localparam logic signed [ACC_W-1:0] HMAX = {{(ACC_W-HB+1){1'b0}}, {(HB-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] HMIN = {{(ACC_W-HB+1){1'b1}}, {(HB-1){1'b0}}};
	localparam logic signed [HB-1:0]    SMAX = {{(HB-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [HB-1:0]    SMIN = {{(HB-SB+1){1'b1}}, {(SB-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (biq_pkg::POST_SHIFT - 1);

	logic signed [XP_W-1:0]  p0, p1, p2;
	logic signed [YP_W-1:0]  p3, p4;
	logic signed [ACC_W-1:0] t0, t1, t2, t3, t4;
	logic signed [ACC_W-1:0] acc, rnd, q, yw;
	logic                    hit_h, hit_s;

	always_comb begin
		p0 = cfg.ff0 * x;
		p1 = cfg.ff1 * hist.x1;
		p2 = cfg.ff2 * hist.x2;
		p3 = cfg.fb1 * hist.y1;
		p4 = cfg.fb2 * hist.y2;

		// each product floored before the sum
		t0 = ACC_W'(p0 >>> biq_pkg::PRE_SHIFT);
		t1 = ACC_W'(p1 >>> biq_pkg::PRE_SHIFT);
		t2 = ACC_W'(p2 >>> biq_pkg::PRE_SHIFT);
		t3 = ACC_W'(p3 >>> biq_pkg::PRE_SHIFT);
		t4 = ACC_W'(p4 >>> biq_pkg::PRE_SHIFT);

		acc = t0 + t1 + t2 - t3 - t4;
		rnd = acc + HALF;                       // round half up
		q   = rnd >>> biq_pkg::POST_SHIFT;

		hit_h = (q > HMAX) || (q < HMIN);
		yw    = (q > HMAX) ? HMAX : ((q < HMIN) ? HMIN : q);
		y     = yw[HB-1:0];

		hit_s  = (y > SMAX) || (y < SMIN);
		sample = (y > SMAX) ? SMAX[SB-1:0] : ((y < SMIN) ? SMIN[SB-1:0] : y[SB-1:0]);

		clipped = hit_h | hit_s;
	end

endmodule

`default_nettype wire

// File: rtl/stereo_biquad_filter_core.sv
// Top level of the stereo biquad filter (direct form 1, Q1.23 samples).
// Depends on biq_pkg, biq_in_if, biq_out_if, biq_cfg_regs, biq_hist, biq_mac.
//
//   channel   dir  handshake       payload
//   audio     in   valid/ready     sample_in, block_end_in
//   filtered  out  valid/ready     sample_out, channel_out, clipped, block_end_out
//   cfg       in   cfg_we only     cfg_index, cfg_wdata
//
// One sample per cycle sustained while the result is taken each cycle; an input
// transfer lands in the input stage, then the multiply-accumulate and history
// update run in a single pass into the result register.
// Reset loads unity gain, stereo mode, left channel and clears all history.
// A stalled result holds in the result register; the input stage still
// advances whenever the result is taken in the same cycle.
`default_nettype none

module stereo_biquad_filter_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	biq_in_if.sink                             audio,
	biq_out_if.source                          filtered,
	input  wire logic                          cfg_we,
	input  wire logic [biq_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [biq_pkg::COEF_BITS-1:0] cfg_wdata
);

	biq_pkg::cfg_t  cfg;
	biq_pkg::hist_t hist;

	// input stage
	logic                                   valid_s1;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic                                   last_s1;

	// result register
	logic                                   out_valid_q;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                                   channel_q;
	logic                                   clipped_q;
	logic                                   last_q;

	logic                                   advance;
	logic                                   filt;
	logic                                   stereo;
	logic                                   next_ch;
	logic [biq_pkg::CH_W-1:0]               ch;
	logic signed [biq_pkg::HIST_BITS-1:0]   y;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] mac_sample;
	logic                                   mac_clipped;

	biq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Mode codes other than mono and stereo bypass the filter untouched.
	assign stereo = (cfg.mode == biq_pkg::MODE_STEREO) && (biq_pkg::CHANNELS > 1);
	assign filt   = (cfg.mode == biq_pkg::MODE_MONO) || (cfg.mode == biq_pkg::MODE_STEREO);
	assign ch     = stereo ? biq_pkg::CH_W'(next_ch) : '0;

	// Move the input stage into the result register when that is free or
	// is being emptied this cycle.
	assign advance      = valid_s1 && (!out_valid_q || filtered.ready);
	assign audio.ready  = !valid_s1 || advance;

	biq_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (advance && filt),
		.toggle  (advance && (cfg.mode == biq_pkg::MODE_STEREO)),
		.last    (last_s1),
		.ch      (ch),
		.x       (sample_s1),
		.y       (y),
		.hist    (hist),
		.next_ch (next_ch)
	);

	biq_mac u_mac (
		.cfg     (cfg),
		.hist    (hist),
		.x       (sample_s1),
		.y       (y),
		.sample  (mac_sample),
		.clipped (mac_clipped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (audio.ready) begin
				valid_s1 <= audio.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (filtered.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (audio.valid && audio.ready) begin
			sample_s1 <= audio.sample_in;
			last_s1   <= audio.block_end_in;
		end
		if (advance) begin
			sample_q  <= filt ? mac_sample : sample_s1;
			channel_q <= filt ? ch[0] : 1'b0;
			clipped_q <= filt ? mac_clipped : 1'b0;
			last_q    <= last_s1;
		end
	end

	assign filtered.valid         = out_valid_q;
	assign filtered.sample_out    = sample_q;
	assign filtered.channel_out   = channel_q;
	assign filtered.clipped       = clipped_q;
	assign filtered.block_end_out = last_q;

endmodule

`default_nettype wire

// File: sim/biq_filter_checker.sv
// Scoreboard for the stereo biquad filter: predicts each filtered sample and checks it.
// Depends on biq_pkg, biq_in_if and biq_out_if. It watches the channels and the cfg port.

module biq_filter_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	biq_in_if                             audio,
	biq_out_if                            filtered,
	input  logic                          cfg_we,
	input  logic [biq_pkg::IDX_W-1:0]     cfg_index,
	input  logic [biq_pkg::COEF_BITS-1:0] cfg_wdata,
	output int                            mismatches,
	output int                            in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import biq_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          channel;
		logic                          clipped;
		logic                          block_end;
	} filt_sample_t;

	cfg_t              coefs;
	hist_t             chan_hist [CHANNELS];
	logic [CH_W-1:0]   next_chan;
	filt_sample_t      expected_samples [$];
	filt_sample_t      got;
	filt_sample_t      want;

	// exact product, floored by the pre-shift
	function automatic longint scaled_product(input longint coef, input longint val);
		return (coef * val) >>> PRE_SHIFT;
	endfunction

	function automatic longint clamp(input longint v, input int bits, inout logic hit);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// one biquad step on the current channel, updating history and channel toggle; bypass modes pass x through
	function automatic filt_sample_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x,
		input logic last);
		filt_sample_t    r;
		longint          acc;
		longint          y;
		longint          s;
		logic            hit;
		logic [CH_W-1:0] ch;
		hist_t           h;
		r.block_end = last;
		if (coefs.mode != MODE_MONO && coefs.mode != MODE_STEREO) begin
			r.sample  = x;
			r.channel = 1'b0;
			r.clipped = 1'b0;
			return r;
		end
		ch  = (coefs.mode == MODE_STEREO) ? next_chan : '0;
		h   = chan_hist[ch];
		acc = scaled_product(coefs.ff0, x) + scaled_product(coefs.ff1, h.x1)
			+ scaled_product(coefs.ff2, h.x2) - scaled_product(coefs.fb1, h.y1)
			- scaled_product(coefs.fb2, h.y2);
		y   = (acc + (longint'(1) << (POST_SHIFT - 1))) >>> POST_SHIFT;
		hit = 1'b0;
		y   = clamp(y, HIST_BITS, hit);
		s   = clamp(y, SAMPLE_BITS, hit);
		h.x2 = h.x1;
		h.x1 = x;
		h.y2 = h.y1;
		h.y1 = y[HIST_BITS-1:0];
		chan_hist[ch] = h;
		if (coefs.mode == MODE_STEREO)
			next_chan = last ? '0 : next_chan + 1'b1;
		r.sample  = s[SAMPLE_BITS-1:0];
		r.channel = ch;
		r.clipped = hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs.ff0  = FF0_RESET;
			coefs.ff1  = '0;
			coefs.ff2  = '0;
			coefs.fb1  = '0;
			coefs.fb2  = '0;
			coefs.mode = MODE_STEREO;
			foreach (chan_hist[i])
				chan_hist[i] = '0;
			next_chan  = '0;
			expected_samples.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FF_COEF_0:    coefs.ff0 = cfg_wdata;
					REG_FF_COEF_1:    coefs.ff1 = cfg_wdata;
					REG_FF_COEF_2:    coefs.ff2 = cfg_wdata;
					REG_FB_COEF_1:    coefs.fb1 = cfg_wdata;
					REG_FB_COEF_2:    coefs.fb2 = cfg_wdata;
					REG_CHANNEL_MODE: coefs.mode = cfg_wdata[MODE_W-1:0];
					default: ;
				endcase
			end
			if (filtered.valid && filtered.ready) begin
				got.sample    = filtered.sample_out;
				got.channel   = filtered.channel_out;
				got.clipped   = filtered.clipped;
				got.block_end = filtered.block_end_out;
				if (expected_samples.size() == 0) begin
					mismatches++;
					$display({"%0t ns: unexpected filtered transfer, expected none,",
						" got %0d ch %0b clip %0b end %0b"}, $time,
						got.sample, got.channel, got.clipped, got.block_end);
				end else begin
					want = expected_samples.pop_front();
					if (got !== want) begin
						mismatches++;
						$display({"%0t ns: filtered mismatch, expected %0d ch %0b clip %0b end %0b,",
							" got %0d ch %0b clip %0b end %0b"}, $time,
							want.sample, want.channel, want.clipped, want.block_end,
							got.sample, got.channel, got.clipped, got.block_end);
					end
				end
			end
			if (audio.valid && audio.ready)
				expected_samples.push_back(filter_sample(audio.sample_in, audio.block_end_in));
		end
		in_flight = expected_samples.size();
	end

endmodule

// File: sim/tb_top.sv
// Testbench top for stereo_biquad_filter_core: clock, reset, stimulus and verdict.
// Depends on biq_pkg, biq_in_if, biq_out_if, the core and biq_filter_checker.
// Directed samples first, then random filter settings with buffered sample streams.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import biq_pkg::*;

	// mode codes outside mono/stereo: the core passes samples straight through
	localparam logic [MODE_W-1:0] MODE_PASS_LO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PASS_HI = 2'd3;
	// register indexes with nothing behind them; writes there must be ignored
	localparam logic [IDX_W-1:0]  REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0]  REG_SPARE_HI = 3'd7;

	localparam logic [COEF_BITS-1:0]   COEF_MAX   = 32'h7FFF_FFFF;
	localparam logic [COEF_BITS-1:0]   COEF_MIN   = 32'h8000_0000;
	localparam logic [COEF_BITS-1:0]   Q_ONE      = FF0_RESET;
	localparam int unsigned            Q_ONE_INT  = 1 << COEF_FRAC;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7F_FFFF;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h80_0000;

	localparam int RANDOM_TARGET = 1900;
	localparam int LONG_HOLD     = 80;	// receiver hold-off, cycles

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [IDX_W-1:0]       cfg_index;
	logic [COEF_BITS-1:0]   cfg_wdata;
	int                     mismatches;
	int                     in_flight;
	int                     burst_left;
	int                     hold_asks;
	int                     holds_done;
	int                     random_items;

	biq_in_if  audio ();
	biq_out_if filtered ();

	stereo_biquad_filter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.audio    (audio),
		.filtered (filtered),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	biq_filter_checker i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.audio     (audio),
		.filtered  (filtered),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.mismatches(mismatches),
		.in_flight (in_flight)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#1_500_000;
		$display("%0t ns: timed out waiting for filtered transfers", $time);
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Sender side. All drives happen on the falling edge; the transfer is
	// seen on the rising edge with valid and ready both high. The sender
	// works in bursts; at the end of a burst valid drops for a random gap.
	// ---------------------------------------------------------------------
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic last);
		int gap;
		@(negedge clk);
		audio.valid        <= 1'b1;
		audio.sample_in    <= s;
		audio.block_end_in <= last;
		do @(posedge clk); while (!audio.ready);
		burst_left--;
		if (burst_left <= 0) begin
			// mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
			@(negedge clk);
			audio.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has been taken.
	task automatic drain();
		@(negedge clk);
		audio.valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	// Full register load, only ever with the core idle. The mode word
	// carries random upper bits since only the low two bits count.
	task automatic load_setting(input logic [COEF_BITS-1:0] c0, c1, c2, d1, d2,
		input logic [MODE_W-1:0] mode);
		logic [COEF_BITS-1:0] mode_word;
		drain();
		mode_word = $urandom();
		mode_word[MODE_W-1:0] = mode;
		write_reg(REG_FF_COEF_0, c0);
		write_reg(REG_FF_COEF_1, c1);
		write_reg(REG_FF_COEF_2, c2);
		write_reg(REG_FB_COEF_1, d1);
		write_reg(REG_FB_COEF_2, d2);
		write_reg(REG_CHANNEL_MODE, mode_word);
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly modest values so the filter stays in range, with the odd
	// full-scale word or extreme to push history into saturation.
	function automatic logic [COEF_BITS-1:0] pick_coef();
		case ($urandom_range(0, 11))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0:       return COEF_MAX;
					1:       return COEF_MIN;
					2:       return '0;
					default: return Q_ONE;
				endcase
			end
			default: return $urandom_range(0, 2 * Q_ONE_INT) - Q_ONE_INT;
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       return SAMPLE_MAX;
					1:       return SAMPLE_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			1, 2, 3: return SAMPLE_BITS'($urandom());
			default: return SAMPLE_BITS'($urandom_range(0, 1 << 18) - (1 << 17));
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Receiver side: ready follows a pattern that changes every so often
	// (always ready, coin toss, mostly stalled, periodic). When the stimulus
	// asks for it, ready is held low through the LONG_HOLD hold-off so that the core
	// fills up and back-pressures the sender.
	// ---------------------------------------------------------------------
	initial begin
		rx_pattern_e pat;
		int          span;
		int          period;
		int          tick;
		filtered.ready = 1'b0;
		holds_done     = 0;
		tick           = 0;
		@(posedge arst_n);
		forever begin
			pat    = rx_pattern_e'($urandom_range(0, 3));
			span   = $urandom_range(10, 120);
			period = $urandom_range(2, 5);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (hold_asks != holds_done) begin
					filtered.ready <= 1'b0;
					repeat (LONG_HOLD - 1) @(negedge clk);
					holds_done++;
				end else begin
					case (pat)
						RX_FREE:     filtered.ready <= 1'b1;
						RX_COIN:     filtered.ready <= 1'($urandom_range(0, 1));
						RX_SPARSE:   filtered.ready <= ($urandom_range(0, 5) == 0);
						RX_PERIODIC: filtered.ready <= ((tick % period) != 0);
						default:     filtered.ready <= 1'b1;
					endcase
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and verdict
	// ---------------------------------------------------------------------
	initial begin
		int                   phase;
		int                   n;
		int                   len;
		int                   phase_items;
		logic [MODE_W-1:0]    mode;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		audio.valid        = 1'b0;
		audio.sample_in    = '0;
		audio.block_end_in = 1'b0;
		hold_asks          = 0;
		burst_left         = 5;
		random_items       = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: unity gain, stereo. Samples pass unchanged, channels
		// alternate; an end-of-buffer mark on either channel puts the next
		// sample back on the left.
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('0, 1'b0);
		send_sample(24'h00_0001, 1'b1);	// ends on the right
		send_sample('1, 1'b1);		// ends on the left
		send_sample(24'h55_5555, 1'b0);
		send_sample(24'hAA_AAAA, 1'b1);

		// Extreme coefficients with full-scale input: output clips at once,
		// and the positive feedback drives the history into saturation.
		load_setting(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, MODE_STEREO);
		repeat (6) send_sample(SAMPLE_MAX, 1'b0);
		repeat (3) send_sample(SAMPLE_MIN, 1'b0);

		// Mono: everything on channel 0, end marks leave the stereo toggle alone.
		load_setting(32'h0800_0000, 32'h0800_0000, '0, 32'hF800_0000, '0, MODE_MONO);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(24'h40_0000, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(24'h12_3456, 1'b1);

		// Both pass-through codes: no filtering and no state change.
		load_setting(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
			MODE_PASS_LO);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample(24'h7A_BCDE, 1'b0);
		load_setting(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
			MODE_PASS_HI);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(24'h00_0001, 1'b1);

		// Random phases. Each loads a fresh setting, then streams buffers
		// that end with an end-of-buffer mark. Stereo buffers are mostly
		// whole left/right pairs; a few are ragged to break the pairing.
		phase = 0;
		while (random_items < RANDOM_TARGET) begin
			case ($urandom_range(0, 19))
				0:          mode = MODE_PASS_LO;
				1:          mode = MODE_PASS_HI;
				2, 3, 4:    mode = MODE_MONO;
				default:    mode = MODE_STEREO;
			endcase
			load_setting(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(), mode);
			// long receiver hold-off while the sender keeps offering
			if (phase == 1 || phase == 5)
				hold_asks++;
			n = $urandom_range(60, 250);
			phase_items = 0;
			while (phase_items < n) begin
				len = $urandom_range(1, 12) * ((mode == MODE_STEREO) ? 2 : 1);
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(1, 9);
				for (int k = 0; k < len; k++)
					send_sample(pick_sample(), k == len - 1);
				phase_items += len;
			end
			random_items += phase_items;
			phase++;
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: stereo_biquad_filter_core.f
rtl/biq_pkg.sv
rtl/biq_in_if.sv
rtl/biq_out_if.sv
rtl/biq_cfg_regs.sv
rtl/biq_hist.sv
rtl/biq_mac.sv
rtl/stereo_biquad_filter_core.sv
sim/biq_filter_checker.sv
sim/tb_top.sv
